// File: src/wsm_pkg.sv
// Package for the Walsh sequency mask row generator.
// Holds shared widths, the configuration register indexes, the row request type
// and the bit-reversal helper. It depends on nothing else.
package wsm_pkg;

    // Fixed field widths.
    localparam int IDX_W      = 16;
    localparam int PIX_W      = 64;
    localparam int ROW_W      = 6;
    localparam int LOG_W      = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int DEF_MAX_SIDE = 64;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_LOG2  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_LOG2 = 1'd1;

    // One row request handed to the pixel logic.
    typedef struct packed {
        logic [ROW_W-1:0] revx;
        logic [ROW_W-1:0] revy;
        logic [LOG_W-1:0] bx;
        logic [ROW_W-1:0] row;
    } t_row_req;

    // Reverses the low n bits of v; bits at and above n read 0.
    function automatic logic [ROW_W-1:0] rev_low(input logic [ROW_W-1:0] v,
                                                 input logic [LOG_W-1:0] n);
        logic [ROW_W-1:0] r;
        r = '0;
        for (int i = 0; i < ROW_W; i++) begin
            if (LOG_W'(i) < n) begin
                r[i] = v[LOG_W'(n - LOG_W'(i) - LOG_W'(1))];
            end
        end
        return r;
    endfunction

endpackage

// File: src/walsh_sequency_mask_rows_unit.sv
// Top level of the Walsh sequency mask row generator.
// Depends on wsm_pkg and wsm_row_pixels.
//
// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_ready    i_pattern_index
// out       output     o_out_valid / i_out_ready  o_row_pixels, o_row_number, o_last_row
// cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// Each pattern index yields 2^height_log2 rows, the log saturated to the maximum
// side, one row per cycle from the row counter while the output side moves; a new
// index is taken in the cycle its last row moves into the output register. The
// result register holds the row under stall; the row counter stops with it.
// Reset is synchronous, active low, and restores both size registers to 6.
module walsh_sequency_mask_rows_unit
    import wsm_pkg::*;
#(
    parameter int MAX_SIDE = DEF_MAX_SIDE
)(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [IDX_W-1:0]      i_pattern_index,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [PIX_W-1:0]      o_row_pixels,
    output logic [ROW_W-1:0]      o_row_number,
    output logic                  o_last_row,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [LOG_W-1:0]      i_cfg_data
);

    localparam int LOG_RAW = $clog2(MAX_SIDE);
    localparam int LOG_LIM = (LOG_RAW > 6) ? 6 : LOG_RAW;

    // Configuration registers.
    logic [LOG_W-1:0] r_width_log2, r_height_log2;
    // Row generator state.
    logic             r_busy;
    logic [ROW_W-1:0] r_revx, r_revy, r_row;
    logic [LOG_W-1:0] r_bx, r_by;
    // Output register.
    logic             r_out_valid, r_last;
    logic [PIX_W-1:0] r_pixels;
    logic [ROW_W-1:0] r_rownum;

    logic             out_load, row_adv, gen_last, in_acc;
    logic [LOG_W-1:0] bx, by;
    logic [ROW_W-1:0] sx, gx, gy, n_revx, n_revy, h_m1;
    logic [IDX_W-1:0] sy;
    logic [PIX_W-1:0] row_pix;
    t_row_req         req;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_log2  <= 3'd6;
            r_height_log2 <= 3'd6;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WIDTH_LOG2:  r_width_log2  <= i_cfg_data;
                CFG_HEIGHT_LOG2: r_height_log2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Saturate the sizes to what the maximum side allows.
    assign bx = (r_width_log2  > LOG_W'(LOG_LIM)) ? LOG_W'(LOG_LIM) : r_width_log2;
    assign by = (r_height_log2 > LOG_W'(LOG_LIM)) ? LOG_W'(LOG_LIM) : r_height_log2;

    // Split the index, Gray-code each part and reverse it over its side.
    assign sx     = i_pattern_index[ROW_W-1:0] & ROW_W'((7'd1 << bx) - 7'd1);
    assign gx     = sx ^ (sx >> 1);
    assign sy     = i_pattern_index >> bx;
    assign gy     = sy[ROW_W-1:0] ^ sy[ROW_W:1];
    assign n_revx = rev_low(gx, bx);
    assign n_revy = rev_low(gy, by);

    // Handshake control.
    assign out_load   = !r_out_valid || i_out_ready;
    assign row_adv    = r_busy && out_load;
    assign h_m1       = ROW_W'((7'd1 << r_by) - 7'd1);
    assign gen_last   = (r_row == h_m1);
    assign o_in_ready = !r_busy || (row_adv && gen_last);
    assign in_acc     = i_in_valid && o_in_ready;

    // Row generator: one row per cycle while the output side moves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (in_acc) begin
            r_busy <= 1'b1;
        end else if (row_adv && gen_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_revx <= n_revx;
            r_revy <= n_revy;
            r_bx   <= bx;
            r_by   <= by;
            r_row  <= '0;
        end else if (row_adv) begin
            r_row <= r_row + ROW_W'(1);
        end
    end

    // Pixels of the current row.
    assign req.revx = r_revx;
    assign req.revy = r_revy;
    assign req.bx   = r_bx;
    assign req.row  = r_row;

    wsm_row_pixels u_row_pixels (
        .i_req    (req),
        .o_pixels (row_pix)
    );

    // Output register parts the generator from the result side.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (row_adv) begin
            r_pixels <= row_pix;
            r_rownum <= r_row;
            r_last   <= gen_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_row_pixels = r_pixels;
    assign o_row_number = r_rownum;
    assign o_last_row   = r_last;

    // A taken index keeps the generator busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_busy)
        else $error("generator idle after an accepted transaction");

    // Rows of one mask follow without a gap once a non-final row is taken.
    a_rows_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_last && i_out_ready) |=> r_out_valid)
        else $error("gap inside a mask");

    // The row counter steps by one between rows of the same mask.
    a_row_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (row_adv && !gen_last) |=> (r_row == $past(r_row) + ROW_W'(1)))
        else $error("row counter skipped");

    // No new index is taken while rows of the current mask remain.
    a_no_early_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !gen_last) |-> !o_in_ready)
        else $error("index accepted before the mask finished");

endmodule

// File: src/wsm_row_pixels.sv
// Pixel logic for one mask row of the Walsh sequency mask row generator.
// Depends on wsm_pkg for the row request type and widths.
module wsm_row_pixels
    import wsm_pkg::*;
(
    input  t_row_req           i_req,
    output logic [PIX_W-1:0]   o_pixels
);

    logic       row_par;
    logic [6:0] width_px;

    // Row parity is shared by every pixel of the row.
    assign row_par  = ^(i_req.revy & i_req.row);
    assign width_px = 7'd1 << i_req.bx;

    // Each pixel within the width is on when the column parity matches the row parity; pixels beyond it are off.
    always_comb begin
        for (int x = 0; x < PIX_W; x++) begin
            if (7'(x) < width_px) begin
                o_pixels[x] = ~((^(i_req.revx & ROW_W'(x))) ^ row_par);
            end else begin
                o_pixels[x] = 1'b0;
            end
        end
    end

endmodule

// File: tb/walsh_sequency_mask_rows_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the Walsh sequency mask row generator.
// Depends on wsm_pkg and walsh_sequency_mask_rows_unit; predicts every mask row itself.
module walsh_sequency_mask_rows_unit_tb;
    import wsm_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 400;

    // One predicted mask row.
    typedef struct {
        logic [PIX_W-1:0] pixels;
        logic [ROW_W-1:0] row;
        logic             last;
    } t_mask_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [IDX_W-1:0]     i_pattern_index = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [PIX_W-1:0]     o_row_pixels;
    logic [ROW_W-1:0]     o_row_number;
    logic                 o_last_row;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_WIDTH_LOG2;
    logic [LOG_W-1:0]     i_cfg_data = '0;

    t_mask_row    pending_rows[$];
    logic [LOG_W-1:0] width_log_copy = 3'd6;
    logic [LOG_W-1:0] height_log_copy = 3'd6;
    int           errors = 0;
    int           quiet_cycles = 0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           hold_cycles = 0;

    walsh_sequency_mask_rows_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_pattern_index (i_pattern_index),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_row_pixels    (o_row_pixels),
        .o_row_number    (o_row_number),
        .o_last_row      (o_last_row),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // Clock with a 20 ns period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Saturates a size register to the largest side that fits 64.
    function automatic int unsigned side_log(input logic [LOG_W-1:0] v);
        return (v > 3'd6) ? 6 : int'(v);
    endfunction

    // Computes every row of the mask for one pattern index and queues it.
    task automatic predict_mask_rows(input logic [IDX_W-1:0] idx);
        int unsigned bx;
        int unsigned by;
        logic [IDX_W-1:0] sx;
        logic [IDX_W-1:0] sy;
        logic [IDX_W-1:0] gx;
        logic [IDX_W-1:0] gy;
        logic [ROW_W-1:0] revx;
        logic [ROW_W-1:0] revy;
        logic             py;
        t_mask_row        r;
        bx = side_log(width_log_copy);
        by = side_log(height_log_copy);
        sx = idx & IDX_W'((1 << bx) - 1);
        sy = idx >> bx;
        gx = sx ^ (sx >> 1);
        gy = sy ^ (sy >> 1);
        revx = '0;
        revy = '0;
        for (int i = 0; i < int'(bx); i++) revx[i] = gx[bx - 1 - i];
        for (int i = 0; i < int'(by); i++) revy[i] = gy[by - 1 - i];
        for (int y = 0; y < (1 << by); y++) begin
            py = ^(revy & ROW_W'(y));
            r.pixels = '0;
            for (int x = 0; x < (1 << bx); x++) begin
                if ((^(revx & ROW_W'(x))) == py) r.pixels[x] = 1'b1;
            end
            r.row = ROW_W'(y);
            r.last = (y == (1 << by) - 1);
            pending_rows.push_back(r);
        end
    endtask

    // Watches all three channels: tracks the size registers, predicts on each
    // input transaction, checks each output transaction and runs the watchdog.
    always @(posedge i_clk) begin
        t_mask_row e;
        if (!i_rst_n) begin
            width_log_copy = 3'd6;
            height_log_copy = 3'd6;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_WIDTH_LOG2) width_log_copy = i_cfg_data;
                else height_log_copy = i_cfg_data;
            end
            if (i_in_valid && o_in_ready) predict_mask_rows(i_pattern_index);
            if (o_out_valid && i_out_ready) begin
                if (pending_rows.size() == 0) begin
                    $error("row %0d arrived with no row expected", o_row_number);
                    errors++;
                end else begin
                    e = pending_rows.pop_front();
                    if (o_row_pixels !== e.pixels) begin
                        $error("row_pixels: expected %h, got %h", e.pixels, o_row_pixels);
                        errors++;
                    end
                    if (o_row_number !== e.row) begin
                        $error("row_number: expected %0d, got %0d", e.row, o_row_number);
                        errors++;
                    end
                    if (o_last_row !== e.last) begin
                        $error("last_row: expected %0b, got %0b", e.last, o_last_row);
                        errors++;
                    end
                end
            end
            if ((i_cfg_valid && o_cfg_ready) || (i_in_valid && o_in_ready) ||
                (o_out_valid && i_out_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("walsh_sequency_mask_rows_unit_tb: errors");
                $finish;
            end
        end
    end

    // Receiver: a long hold-off when one is requested, else random stalls.
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            i_out_ready <= 1'b0;
            hold_cycles = hold_cycles - 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Waits until every predicted row has been taken. The first edge lets the
    // monitor record a transaction accepted at the edge the caller returned on.
    task automatic drain_rows();
        @(posedge i_clk);
        while (pending_rows.size() != 0) @(posedge i_clk);
    endtask

    // Offers one pattern index, with random gaps before it.
    task automatic send_index(input logic [IDX_W-1:0] idx);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pattern_index <= idx;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Writes both size registers once the block is idle.
    task automatic set_mask_size(input logic [LOG_W-1:0] wl, input logic [LOG_W-1:0] hl);
        drain_rows();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_WIDTH_LOG2;
        i_cfg_data <= wl;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_HEIGHT_LOG2;
        i_cfg_data <= hl;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Full 64 by 64 mask straight after reset: all index bits low, all high, and one mixed index.
    task automatic test_reset_size();
        send_index(16'h0000);
        send_index(16'hFFFF);
        send_index(16'h0041);
        i_in_valid <= 1'b0;
    endtask

    // Size extremes, saturation of an oversize log, one pixel, one column, one row,
    // a small mask and indexes too large for the mask.
    task automatic test_size_extremes();
        set_mask_size(3'd0, 3'd0);
        send_index(16'h0000);
        send_index(16'hFFFF);
        i_in_valid <= 1'b0;
        set_mask_size(3'd7, 3'd7);
        send_index(16'h0FFF);
        send_index(16'h1000);
        i_in_valid <= 1'b0;
        set_mask_size(3'd0, 3'd6);
        send_index(16'd5);
        send_index(16'd63);
        i_in_valid <= 1'b0;
        set_mask_size(3'd6, 3'd0);
        send_index(16'd40);
        send_index(16'hABCD);
        i_in_valid <= 1'b0;
        set_mask_size(3'd3, 3'd2);
        send_index(16'd7);
        send_index(16'd8);
        send_index(16'd31);
        send_index(16'd32);
        send_index(16'hFFFF);
        i_in_valid <= 1'b0;
    endtask

    // The receiver holds off while indexes keep coming, so the input stalls;
    // then the sender waits for every row.
    task automatic test_output_stall();
        set_mask_size(3'd2, 3'd3);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles = LONG_HOLD;
        for (int n = 0; n < 12; n++) send_index(IDX_W'($urandom));
        i_in_valid <= 1'b0;
        drain_rows();
    endtask

    // Random sizes, mostly short masks, with indexes half inside the mask.
    task automatic test_random_masks(input int send_pct, input int recv_pct);
        logic [LOG_W-1:0] wl;
        logic [LOG_W-1:0] hl;
        int unsigned      span;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int s = 0; s < 4; s++) begin
            wl = LOG_W'($urandom_range(7));
            hl = ($urandom_range(3) == 0) ? LOG_W'($urandom_range(7, 4))
                                          : LOG_W'($urandom_range(3));
            set_mask_size(wl, hl);
            span = 1 << (side_log(wl) + side_log(hl));
            for (int n = 0; n < 24; n++) begin
                if ($urandom_range(1) == 0) send_index(IDX_W'($urandom_range(span - 1)));
                else send_index(IDX_W'($urandom));
            end
            i_in_valid <= 1'b0;
        end
    endtask

    // Test sequence.
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 29;
        recv_idle_pct = 60;
        test_reset_size();
        test_size_extremes();
        test_output_stall();
        test_random_masks(29, 60);
        test_random_masks(60, 29);
        test_random_masks(0, 0);
        drain_rows();
        repeat (20) @(posedge i_clk);
        if (pending_rows.size() != 0) begin
            $error("%0d rows never arrived", pending_rows.size());
            errors++;
        end
        if (errors == 0) begin
            $display("walsh_sequency_mask_rows_unit_tb: clean");
        end else begin
            $display("walsh_sequency_mask_rows_unit_tb: errors");
        end
        $finish;
    end

endmodule
